/* hw/rtl/kmfs_pkg.sv */
// Shared types, key codes and result codes for the keyboard/mouse focus switch.
package kmfs_pkg;

   localparam int MAX_TARGETS_DEFAULT = 16;
   localparam int RSP_DEPTH           = 4;
   localparam int RSP_PTR_W           = $clog2(RSP_DEPTH);

   // keyboard scan codes
   localparam logic [7:0] KB_CTRL     = 8'h4c;
   localparam logic [7:0] KEY_F1      = 8'h05;
   localparam logic [7:0] KEY_ESC     = 8'h1d;
   localparam logic [7:0] KEY_1       = 8'h1e;
   localparam logic [7:0] KEY_0       = 8'h27;
   localparam logic [7:0] KEY_K       = 8'h54;
   localparam logic [7:0] KEY_M       = 8'h6a;
   localparam logic [7:0] KB_SPACE    = 8'h79;
   localparam logic [7:0] KB_IDLE     = 8'h7f;
   localparam logic [7:0] KEY_UP      = 8'h80;
   localparam logic [7:0] KEY_RESET   = 8'hff;
   localparam logic [7:0] KEY_LAYOUT  = 8'hfe;
   localparam logic [7:0] KEY_ERROR   = 8'h7e;
   localparam logic [7:0] KB_CTRL_UP  = KB_CTRL | KEY_UP;

   // mode flag bit positions
   localparam int FLAG_GETID  = 0;
   localparam int FLAG_GETLAY = 1;
   localparam int FLAG_CTRL   = 2;
   localparam int FLAG_SWING  = 3;
   localparam int FLAG_SWED   = 4;
   localparam int FLAG_MULTI  = 5;
   localparam int FLAG_ONLYK  = 6;
   localparam int FLAG_ONLYM  = 7;

   // switch target meaning "invalid selection"
   localparam logic [8:0] UNIT_NONE = 9'h100;

   typedef enum logic [2:0] {
      KIND_KEY         = 3'd0,
      KIND_MOUSE       = 3'd1,
      KIND_FOCUS       = 3'd2,
      KIND_BEEP        = 3'd3,
      KIND_BELL_CANCEL = 3'd4
   } kmfs_kind_type;

   typedef struct packed {
      logic [3:0] kbd_focus;
      logic [3:0] mouse_focus;
      logic [7:0] flags;
      logic [7:0] multi_number;
      logic [7:0] kbd_type_code;
      logic [7:0] kbd_layout_code;
   } kmfs_state_type;

   typedef struct packed {
      kmfs_kind_type kind;
      logic [3:0]    target;
      logic [7:0]    data;
   } kmfs_result_type;

   typedef struct packed {
      kmfs_kind_type kind;
      logic [3:0]    target;
      logic [3:0]    mouse_target;
      logic [7:0]    data;
      logic          last;
   } kmfs_entry_type;

endpackage

/* hw/rtl/kmfs_step.sv */
// Next-state and result logic for one received keyboard or mouse byte.
module kmfs_step (
   input  logic                       in_opcode,
   input  logic [7:0]                 in_data,
   input  kmfs_pkg::kmfs_state_type   cur,
   input  logic [4:0]                 count,
   output kmfs_pkg::kmfs_state_type   nxt,
   output logic [1:0]                 res_count,
   output kmfs_pkg::kmfs_result_type  res0,
   output kmfs_pkg::kmfs_result_type  res1
);

   always_comb begin
      kmfs_pkg::kmfs_state_type  s;
      kmfs_pkg::kmfs_result_type res_v [2];
      logic [1:0]  n;
      logic        do_sw;
      logic [8:0]  unit;
      logic        changed;
      logic        is_digit;
      logic [3:0]  dig;
      logic [11:0] prod;
      logic [7:0]  c;

      c        = in_data;
      s        = cur;
      n        = 2'd0;
      res_v[0] = '0;
      res_v[1] = '0;
      do_sw    = 1'b0;
      unit     = '0;
      changed  = 1'b0;
      is_digit = (c >= kmfs_pkg::KEY_1) && (c <= kmfs_pkg::KEY_0);
      dig      = (c == kmfs_pkg::KEY_0) ? 4'd0 : 4'(c - kmfs_pkg::KEY_1 + 8'd1);
      prod     = ({4'd0, cur.multi_number} << 3) + ({4'd0, cur.multi_number} << 1)
                 + {8'd0, dig};

      if (in_opcode) begin
         if ({1'b0, cur.mouse_focus} < count) begin
            res_v[n[0]] = '{kind: kmfs_pkg::KIND_MOUSE, target: cur.mouse_focus, data: c};
            n = n + 2'd1;
         end
      end else if ({1'b0, cur.kbd_focus} < count) begin
         if (s.flags[kmfs_pkg::FLAG_GETID]) begin
            s.kbd_type_code = c;
            s.flags[kmfs_pkg::FLAG_GETID] = 1'b0;
         end else if (s.flags[kmfs_pkg::FLAG_GETLAY]) begin
            s.kbd_layout_code = c;
            s.flags[kmfs_pkg::FLAG_GETLAY] = 1'b0;
         end else if (c == kmfs_pkg::KEY_RESET) begin
            s.flags[kmfs_pkg::FLAG_GETID] = 1'b1;
         end else if (c == kmfs_pkg::KEY_LAYOUT) begin
            s.flags[kmfs_pkg::FLAG_GETLAY] = 1'b1;
         end else if (c == kmfs_pkg::KEY_ERROR) begin
            s = s;
         end else if (s.flags[kmfs_pkg::FLAG_SWING]) begin
            // release of Ctrl during switching still reaches the old target
            if (s.flags[kmfs_pkg::FLAG_CTRL] && c == kmfs_pkg::KB_CTRL_UP) begin
               res_v[n[0]] = '{kind: kmfs_pkg::KIND_KEY, target: s.kbd_focus, data: c};
               n = n + 2'd1;
               s.flags[kmfs_pkg::FLAG_CTRL] = 1'b0;
            end
            if (!(c[7] || c == kmfs_pkg::KB_IDLE)) begin
               if (c == kmfs_pkg::KEY_K) begin
                  s.flags[kmfs_pkg::FLAG_ONLYM] = 1'b0;
                  s.flags[kmfs_pkg::FLAG_ONLYK] = 1'b1;
               end else if (c == kmfs_pkg::KEY_M) begin
                  s.flags[kmfs_pkg::FLAG_ONLYK] = 1'b0;
                  s.flags[kmfs_pkg::FLAG_ONLYM] = 1'b1;
               end else if (s.flags[kmfs_pkg::FLAG_MULTI]) begin
                  if (is_digit) begin
                     s.multi_number = (prod > 12'd255) ? 8'd255 : prod[7:0];
                  end else if (c == kmfs_pkg::KB_SPACE) begin
                     do_sw = 1'b1;
                     unit  = (s.multi_number == 8'd0) ? kmfs_pkg::UNIT_NONE
                             : ({1'b0, s.multi_number} - 9'd1);
                  end else begin
                     do_sw = 1'b1;
                     unit  = kmfs_pkg::UNIT_NONE;
                  end
               end else if (c == kmfs_pkg::KEY_F1) begin
                  // second Ctrl-F1 passes F1 through and leaves switching
                  if (s.flags[kmfs_pkg::FLAG_CTRL]) begin
                     res_v[n[0]] = '{kind: kmfs_pkg::KIND_KEY, target: s.kbd_focus,
                                     data: kmfs_pkg::KEY_F1};
                     n = n + 2'd1;
                     s.flags[kmfs_pkg::FLAG_SWING] = 1'b0;
                  end
               end else if (is_digit) begin
                  do_sw = 1'b1;
                  unit  = {1'b0, c - kmfs_pkg::KEY_1};
               end else if (c == kmfs_pkg::KB_SPACE) begin
                  s.flags[kmfs_pkg::FLAG_MULTI] = 1'b1;
                  s.multi_number = 8'd0;
               end else if (c == kmfs_pkg::KEY_ESC) begin
                  s.flags[kmfs_pkg::FLAG_SWING] = 1'b0;
                  s.flags[kmfs_pkg::FLAG_SWED]  = 1'b1;
                  res_v[n[0]] = '{kind: kmfs_pkg::KIND_BELL_CANCEL, target: s.kbd_focus,
                                  data: 8'd0};
                  n = n + 2'd1;
               end else begin
                  do_sw = 1'b1;
                  unit  = kmfs_pkg::UNIT_NONE;
               end
            end
         end else if (s.flags[kmfs_pkg::FLAG_SWED]) begin
            // drop bytes until the keyboard goes idle
            if (c == kmfs_pkg::KB_IDLE) begin
               s.flags[kmfs_pkg::FLAG_SWED] = 1'b0;
            end
         end else begin
            if (c == kmfs_pkg::KEY_F1 && s.flags[kmfs_pkg::FLAG_CTRL]) begin
               s.flags[kmfs_pkg::FLAG_ONLYK] = 1'b0;
               s.flags[kmfs_pkg::FLAG_ONLYM] = 1'b0;
               s.flags[kmfs_pkg::FLAG_SWING] = 1'b1;
            end else begin
               if (c == kmfs_pkg::KB_CTRL) begin
                  s.flags[kmfs_pkg::FLAG_CTRL] = 1'b1;
               end else if (c == kmfs_pkg::KB_CTRL_UP || c == kmfs_pkg::KB_IDLE) begin
                  s.flags[kmfs_pkg::FLAG_CTRL] = 1'b0;
               end
               res_v[n[0]] = '{kind: kmfs_pkg::KIND_KEY, target: s.kbd_focus, data: c};
               n = n + 2'd1;
            end
         end
      end

      if (do_sw) begin
         if (!s.flags[kmfs_pkg::FLAG_ONLYM] && s.flags[kmfs_pkg::FLAG_CTRL]) begin
            res_v[n[0]] = '{kind: kmfs_pkg::KIND_KEY, target: s.kbd_focus,
                            data: kmfs_pkg::KB_CTRL_UP};
            n = n + 2'd1;
            s.flags[kmfs_pkg::FLAG_CTRL] = 1'b0;
         end
         s.flags[kmfs_pkg::FLAG_SWING] = 1'b0;
         s.flags[kmfs_pkg::FLAG_MULTI] = 1'b0;
         s.flags[kmfs_pkg::FLAG_SWED]  = 1'b1;
         if (unit >= {4'd0, count}) begin
            res_v[n[0]] = '{kind: kmfs_pkg::KIND_BEEP, target: s.kbd_focus, data: 8'd0};
            n = n + 2'd1;
         end else begin
            if (!s.flags[kmfs_pkg::FLAG_ONLYM] && unit != {5'd0, s.kbd_focus}) begin
               s.kbd_focus = unit[3:0];
               changed = 1'b1;
            end
            if (!s.flags[kmfs_pkg::FLAG_ONLYK] && unit != {5'd0, s.mouse_focus}) begin
               s.mouse_focus = unit[3:0];
               changed = 1'b1;
            end
            if (changed) begin
               res_v[n[0]] = '{kind: kmfs_pkg::KIND_FOCUS, target: s.kbd_focus, data: 8'd0};
               n = n + 2'd1;
            end
         end
      end

      nxt       = s;
      res_count = n;
      res0      = res_v[0];
      res1      = res_v[1];
   end

endmodule

/* hw/rtl/kmfs_rsp_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one per transaction.
module kmfs_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               push_count,
   input  kmfs_pkg::kmfs_entry_type push0,
   input  kmfs_pkg::kmfs_entry_type push1,
   output logic                     room2,
   output logic                     out_valid,
   input  logic                     out_stall,
   output kmfs_pkg::kmfs_entry_type out_entry
);

   localparam int CNT_W = kmfs_pkg::RSP_PTR_W + 1;

   kmfs_pkg::kmfs_entry_type mem_ff [kmfs_pkg::RSP_DEPTH];

   logic [kmfs_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [kmfs_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [kmfs_pkg::RSP_PTR_W-1:0] wr_ptr_nxt1;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           pop;

   assign wr_ptr_nxt1 = wr_ptr_ff + 1'b1;
   assign out_valid   = (count_ff != '0);
   assign out_entry   = mem_ff[rd_ptr_ff];
   assign room2       = (count_ff <= CNT_W'(kmfs_pkg::RSP_DEPTH - 2));
   assign pop         = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + kmfs_pkg::RSP_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + kmfs_pkg::RSP_PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_nxt1] <= push1;
      end
   end

endmodule

/* hw/rtl/keyboard_mouse_focus_switch_core.sv */
// Top level of the keyboard/mouse focus switch.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall opcode, data
//   rsp      out        rsp_valid/rsp_stall kind, target, mouse_target, data_res, last
//   csr      in         csr_valid/csr_ready target_count
//
// One byte is taken per cycle when not stalled; its state update and its zero to two
// results are worked out in the accepting cycle and land in a four-entry result queue.
// Results leave one per unstalled cycle; an item's two results take two transactions.
// req_stall rises while the queue has room for fewer than two results.
// Synchronous reset clears focus, flags and the queue and sets target_count to 1.
module keyboard_mouse_focus_switch_core #(
   parameter int MAX_TARGETS = kmfs_pkg::MAX_TARGETS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [3:0] rsp_target,
   output logic [3:0] rsp_mouse_target,
   output logic [7:0] rsp_data_res,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_target_count
);

   kmfs_pkg::kmfs_state_type  state_ff, state_in, step_nxt;
   kmfs_pkg::kmfs_result_type res0, res1;
   kmfs_pkg::kmfs_entry_type  push0, push1, head;
   logic [4:0] target_count_ff, target_count_in;
   logic [4:0] count_eff;
   logic [1:0] res_count, push_count;
   logic       room2;
   logic       accept;

   assign csr_ready = 1'b1;
   assign req_stall = !room2;
   assign accept    = req_valid && !req_stall;

   // clamp the register to the number of targets built
   assign count_eff = (target_count_ff > 5'(MAX_TARGETS)) ? 5'(MAX_TARGETS) : target_count_ff;

   kmfs_step u_step (
      .in_opcode (req_opcode),
      .in_data   (req_data),
      .cur       (state_ff),
      .count     (count_eff),
      .nxt       (step_nxt),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   always_comb begin
      state_in        = accept ? step_nxt : state_ff;
      target_count_in = (csr_valid && csr_ready) ? csr_target_count : target_count_ff;
      push_count      = accept ? res_count : 2'd0;
      push0 = '{kind: res0.kind, target: res0.target, mouse_target: step_nxt.mouse_focus,
                data: res0.data, last: (res_count == 2'd1)};
      push1 = '{kind: res1.kind, target: res1.target, mouse_target: step_nxt.mouse_focus,
                data: res1.data, last: 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= '0;
         target_count_ff <= 5'd1;
      end else begin
         state_ff        <= state_in;
         target_count_ff <= target_count_in;
      end
   end

   kmfs_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (push0),
      .push1      (push1),
      .room2      (room2),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_entry  (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_target       = head.target;
   assign rsp_mouse_target = head.mouse_target;
   assign rsp_data_res     = head.data;
   assign rsp_last         = head.last;

endmodule

/* hw/rtl/kmfs_checker.sv */
// Port-level assertions for the focus switch core, bound to the top level.
module kmfs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [3:0] rsp_target,
   input logic [3:0] rsp_mouse_target,
   input logic [7:0] rsp_data_res,
   input logic       rsp_last
);

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_target)
         && $stable(rsp_data_res) && $stable(rsp_last))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result queue not empty after reset");

   // a mouse byte always goes to the current mouse focus and stands alone
   a_mouse_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == kmfs_pkg::KIND_MOUSE |-> rsp_target == rsp_mouse_target
         && rsp_last)
      else $error("mouse byte target mismatch");

   a_event_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == kmfs_pkg::KIND_FOCUS || rsp_kind == kmfs_pkg::KIND_BEEP
         || rsp_kind == kmfs_pkg::KIND_BELL_CANCEL) |-> rsp_data_res == 8'd0)
      else $error("event carries data");

endmodule

bind keyboard_mouse_focus_switch_core kmfs_checker u_kmfs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_target       (rsp_target),
   .rsp_mouse_target (rsp_mouse_target),
   .rsp_data_res     (rsp_data_res),
   .rsp_last         (rsp_last)
);
